// ----- sv/pdsc_pkg.sv -----
package pdsc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned PlaneW = 64;
  localparam int unsigned AccW   = 128;
  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;

  typedef enum logic [1:0] {
    KIND_THREE_PTS = 2'd0,
    KIND_NORMAL_PT = 2'd1,
    KIND_VERTEX    = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  localparam logic [1:0] VERDICT_ABOVE = 2'b01;
  localparam logic [1:0] VERDICT_ON    = 2'b00;
  localparam logic [1:0] VERDICT_BELOW = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_ORV,
    ST_BITLEN,
    ST_SCALE,
    ST_SQ,
    ST_SQRT,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OFFS,
    ST_NP,
    ST_CLS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   en;
    logic                   hi;
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    valid;
    logic                    hi;
    logic signed [ProdW-1:0] p;
  } mul_rsp_t;

  // Saturate a wide signed value to the 64-bit plane format
  function automatic logic signed [PlaneW-1:0] sat_plane(input logic signed [AccW-1:0] v);
    if (v[AccW-1:PlaneW-1] == {(AccW-PlaneW+1){v[AccW-1]}}) begin
      return v[PlaneW-1:0];
    end else if (v[AccW-1]) begin
      return {1'b1, {(PlaneW-1){1'b0}}};
    end else begin
      return {1'b0, {(PlaneW-1){1'b1}}};
    end
  endfunction

endpackage

// ----- sv/pdsc_if.sv -----
interface pdsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic signed [pdsc_pkg::CoordW-1:0]   a_x;
  logic signed [pdsc_pkg::CoordW-1:0]   a_y;
  logic signed [pdsc_pkg::CoordW-1:0]   a_z;
  logic signed [pdsc_pkg::CoordW-1:0]   b_x;
  logic signed [pdsc_pkg::CoordW-1:0]   b_y;
  logic signed [pdsc_pkg::CoordW-1:0]   b_z;
  logic signed [pdsc_pkg::CoordW-1:0]   c_x;
  logic signed [pdsc_pkg::CoordW-1:0]   c_y;
  logic signed [pdsc_pkg::CoordW-1:0]   c_z;
  logic                                 last;

  modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last,
                  input ready);
  modport sink   (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last,
                  output ready);
endinterface

interface pdsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [1:0]                    verdict;
  logic                                 degenerate;
  logic signed [pdsc_pkg::PlaneW-1:0]   normal_x;
  logic signed [pdsc_pkg::PlaneW-1:0]   normal_y;
  logic signed [pdsc_pkg::PlaneW-1:0]   normal_z;
  logic signed [pdsc_pkg::PlaneW-1:0]   plane_d;

  modport source (output valid, verdict, degenerate, normal_x, normal_y, normal_z, plane_d,
                  input ready);
  modport sink   (input valid, verdict, degenerate, normal_x, normal_y, normal_z, plane_d,
                  output ready);
endinterface

// ----- sv/pdsc_mul.sv -----
module pdsc_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdsc_pkg::mul_req_t   req,
  output pdsc_pkg::mul_rsp_t   rsp
);

  logic                                 valid_r;
  logic                                 hi_r;
  logic signed [pdsc_pkg::ProdW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.en;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= req.hi;
    p_r  <= $signed(req.a) * $signed(req.b);
  end

  assign rsp.valid = valid_r;
  assign rsp.hi    = hi_r;
  assign rsp.p     = p_r;

endmodule

// ----- sv/pdsc_isqrt.sv -----
// Integer square root of a 64-bit value to a 32-bit root, bit-serial; a start while busy restarts it
module pdsc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [63:0] trial;
  logic        ge;

  assign trial = r_r + bit_r;
  assign ge    = (v_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

// ----- sv/pdsc_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
module pdsc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_r, quo_r[63]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/plane_define_and_side_classify_core.sv -----
// Plane store and point-set side test. One plane (normal, offset, Q32.32) is held and
// reloaded either from a normal and a point or from three points; vertices are then
// tested against it one at a time, and the vertex marked last (or an empty-set item)
// returns the verdict for the set. A single registered 33x33 multiplier carries every
// product, accumulating into a 128-bit register. A vertex takes six partial products of
// normal by vertex, one drain step and one finish step, then the done state when it
// yields a result; a normal-and-point load takes three products. A three-point load
// runs six cross-product terms, a bit-by-bit length normalisation of the 68-bit cross
// product, a square root and three bit-serial divisions for the unit normal, which
// dominate. A new transaction is taken only while the sequencer is idle; a finished
// result waits in the output register meanwhile.
module plane_define_and_side_classify_core #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  pdsc_in_if.sink            in_ch,
  pdsc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned Frac   = COORD_FRAC_BITS;
  localparam int unsigned NpUp   = (32 >= 2 * Frac) ? 32 - 2 * Frac : 0;
  localparam int unsigned NpDn   = (32 >= 2 * Frac) ? 0 : 2 * Frac - 32;
  localparam int unsigned NormUp = 32 - Frac;
  localparam logic signed [7:0] ExpBias = 8'(32 - 2 * int'(Frac));
  localparam logic [31:0] MinLenReset = 32'd4295;

  typedef logic signed [pdsc_pkg::AccW-1:0] acc_t;

  pdsc_pkg::state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  comp_r, comp_nxt;

  pdsc_pkg::kind_t kind_r;
  logic        last_r;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic signed [31:0] pc_r [3];

  logic signed [63:0] normal_r [3];
  logic signed [63:0] offset_r;
  logic signed [63:0] nn_r [3];
  logic signed [67:0] cr_r [3];
  logic signed [31:0] cs_r [3];
  logic [67:0] sv_r;
  logic [6:0]  bl_r;
  logic signed [7:0] sh_r;
  logic [31:0] len_r;
  acc_t        acc_r;
  logic [31:0] min_len_r;
  logic        seen_above_r, seen_below_r, seen_on_r;
  logic [1:0]  res_verdict_r;
  logic        res_degen_r;

  logic        out_valid_r;
  logic [1:0]  out_verdict_r;
  logic        out_degen_r;
  logic signed [63:0] out_nx_r, out_ny_r, out_nz_r, out_d_r;

  pdsc_pkg::mul_req_t mreq;
  pdsc_pkg::mul_rsp_t mrsp;

  logic        accept, issue, post, load_out;
  logic [2:0]  mac_len;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  acc_t        addend, acc_sum;
  logic [67:0] mag [3];
  logic [67:0] orv;
  logic signed [7:0] e_exp;
  logic [63:0] lenq;
  logic        too_short;
  logic [5:0]  sc_amt;
  logic signed [67:0] sc_val;
  logic [31:0] cs_mag;
  logic        cls_below, cls_zero, na, nb, non;
  logic [1:0]  cls_verdict;
  logic [1:0]  ia, ib;
  logic signed [32:0] e1_v, e2_v;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic [1:0] idx_next(input logic [1:0] k);
    case (k)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_prev(input logic [1:0] k);
    case (k)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [67:0] abs68(input logic signed [67:0] v);
    return v[67] ? 68'(-v) : v;
  endfunction

  pdsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  pdsc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (acc_r[63:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  pdsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared datapath terms
  always_comb begin
    addend = '0;
    if (mrsp.valid) begin
      if (mrsp.hi) begin
        addend = {{30{mrsp.p[65]}}, mrsp.p, 32'b0};
      end else begin
        addend = {{62{mrsp.p[65]}}, mrsp.p};
      end
    end
    acc_sum = acc_r + addend;

    for (int k = 0; k < 3; k++) begin
      mag[k] = abs68(cr_r[k]);
    end
    orv = mag[0] | mag[1] | mag[2];

    e_exp = sh_r + ExpBias;
    if (e_exp[7]) begin
      lenq = {32'b0, len_r} >> 6'(-e_exp);
    end else begin
      lenq = {32'b0, len_r} << e_exp[5:0];
    end
    too_short = (e_exp < 8'sd32) && (lenq < {32'b0, min_len_r});

    sc_amt = sh_r[7] ? 6'(-sh_r) : sh_r[5:0];
    sc_val = sh_r[7] ? (cr_r[comp_r] <<< sc_amt) : (cr_r[comp_r] >>> sc_amt);

    cs_mag = cs_r[comp_r][31] ? 32'(-cs_r[comp_r]) : cs_r[comp_r];
    div_dividend = {cs_mag, 32'b0} + {33'b0, len_r[31:1]};

    cls_below = acc_r[pdsc_pkg::AccW-1];
    cls_zero  = (acc_r == '0);
    na  = seen_above_r | (!cls_below && !cls_zero);
    nb  = seen_below_r | cls_below;
    non = seen_on_r | cls_zero;
    if (non) begin
      cls_verdict = pdsc_pkg::VERDICT_ON;
    end else if (nb) begin
      cls_verdict = na ? pdsc_pkg::VERDICT_ON : pdsc_pkg::VERDICT_BELOW;
    end else begin
      cls_verdict = pdsc_pkg::VERDICT_ABOVE;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdsc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          case (pdsc_pkg::kind_t'(in_ch.kind))
            pdsc_pkg::KIND_THREE_PTS: state_nxt = pdsc_pkg::ST_CROSS;
            pdsc_pkg::KIND_NORMAL_PT: state_nxt = pdsc_pkg::ST_NP;
            pdsc_pkg::KIND_VERTEX:    state_nxt = pdsc_pkg::ST_CLS;
            default:                  state_nxt = pdsc_pkg::ST_DONE;
          endcase
        end
      end
      pdsc_pkg::ST_CROSS: if (post && comp_r == 2'd2) state_nxt = pdsc_pkg::ST_ORV;
      pdsc_pkg::ST_ORV: begin
        state_nxt = (orv == '0) ? pdsc_pkg::ST_DONE : pdsc_pkg::ST_BITLEN;
      end
      pdsc_pkg::ST_BITLEN: if (sv_r == '0) state_nxt = pdsc_pkg::ST_SCALE;
      pdsc_pkg::ST_SCALE:  if (comp_r == 2'd2) state_nxt = pdsc_pkg::ST_SQ;
      pdsc_pkg::ST_SQ:     if (post) state_nxt = pdsc_pkg::ST_SQRT;
      pdsc_pkg::ST_SQRT:   if (sqrt_done) state_nxt = pdsc_pkg::ST_CHECK;
      pdsc_pkg::ST_CHECK: begin
        state_nxt = too_short ? pdsc_pkg::ST_DONE : pdsc_pkg::ST_DIV_GO;
      end
      pdsc_pkg::ST_DIV_GO: state_nxt = pdsc_pkg::ST_DIV_WAIT;
      pdsc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (comp_r == 2'd2) ? pdsc_pkg::ST_OFFS : pdsc_pkg::ST_DIV_GO;
        end
      end
      pdsc_pkg::ST_OFFS: if (post) state_nxt = pdsc_pkg::ST_DONE;
      pdsc_pkg::ST_NP:   if (post) state_nxt = pdsc_pkg::ST_DONE;
      pdsc_pkg::ST_CLS: begin
        if (post) state_nxt = last_r ? pdsc_pkg::ST_DONE : pdsc_pkg::ST_IDLE;
      end
      pdsc_pkg::ST_DONE: if (load_out) state_nxt = pdsc_pkg::ST_IDLE;
      default: state_nxt = pdsc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    case (state_r)
      pdsc_pkg::ST_CROSS:              mac_len = 3'd2;
      pdsc_pkg::ST_SQ, pdsc_pkg::ST_NP: mac_len = 3'd3;
      pdsc_pkg::ST_OFFS, pdsc_pkg::ST_CLS: mac_len = 3'd6;
      default:                         mac_len = 3'd0;
    endcase
    issue = (mac_len != 3'd0) && (step_r < mac_len);
    post  = (mac_len != 3'd0) && (step_r == mac_len + 3'd1);

    accept     = (state_r == pdsc_pkg::ST_IDLE) && in_ch.valid;
    load_out   = (state_r == pdsc_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
    sqrt_start = (state_r == pdsc_pkg::ST_SQ) && post;
    div_start  = (state_r == pdsc_pkg::ST_DIV_GO);

    step_nxt = step_r;
    if (mac_len != 3'd0) begin
      step_nxt = post ? 3'd0 : step_r + 3'd1;
    end

    comp_nxt = comp_r;
    case (state_r)
      pdsc_pkg::ST_IDLE:     comp_nxt = 2'd0;
      pdsc_pkg::ST_BITLEN:   comp_nxt = 2'd0;
      pdsc_pkg::ST_CHECK:    comp_nxt = 2'd0;
      pdsc_pkg::ST_CROSS:    if (post) comp_nxt = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      pdsc_pkg::ST_SCALE:    comp_nxt = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      pdsc_pkg::ST_DIV_WAIT: if (div_done) comp_nxt = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      default:               comp_nxt = comp_r;
    endcase

    // Multiplier operands: split steps take the low then high half of a 64-bit factor
    ia = step_r[2:1];
    ib = step_r[1:0];
    e1_v = '0;
    e2_v = '0;
    mreq.en = issue;
    mreq.hi = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    case (state_r)
      pdsc_pkg::ST_CROSS: begin
        if (step_r[0]) begin
          e1_v = sx33(pb_r[idx_prev(comp_r)]) - sx33(pa_r[idx_prev(comp_r)]);
          e2_v = sx33(pc_r[idx_next(comp_r)]) - sx33(pb_r[idx_next(comp_r)]);
          mreq.a = -e1_v;
        end else begin
          e1_v = sx33(pb_r[idx_next(comp_r)]) - sx33(pa_r[idx_next(comp_r)]);
          e2_v = sx33(pc_r[idx_prev(comp_r)]) - sx33(pb_r[idx_prev(comp_r)]);
          mreq.a = e1_v;
        end
        mreq.b = e2_v;
      end
      pdsc_pkg::ST_SQ: begin
        mreq.a = sx33(cs_r[ib]);
        mreq.b = sx33(cs_r[ib]);
      end
      pdsc_pkg::ST_NP: begin
        mreq.a = sx33(pa_r[ib]);
        mreq.b = sx33(pb_r[ib]);
      end
      pdsc_pkg::ST_OFFS: begin
        mreq.hi = step_r[0];
        mreq.a  = step_r[0] ? sx33(nn_r[ia][63:32]) : {1'b0, nn_r[ia][31:0]};
        mreq.b  = sx33(pa_r[ia]);
      end
      pdsc_pkg::ST_CLS: begin
        mreq.hi = step_r[0];
        mreq.a  = step_r[0] ? sx33(normal_r[ia][63:32]) : {1'b0, normal_r[ia][31:0]};
        mreq.b  = sx33(pa_r[ia]);
      end
      default: begin
        mreq.a = '0;
      end
    endcase
  end

  assign in_ch.ready = (state_r == pdsc_pkg::ST_IDLE);

  // Control and plane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pdsc_pkg::ST_IDLE;
      step_r       <= '0;
      comp_r       <= '0;
      seen_above_r <= 1'b0;
      seen_below_r <= 1'b0;
      seen_on_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      min_len_r    <= MinLenReset;
      offset_r     <= '0;
      for (int k = 0; k < 3; k++) begin
        normal_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
      if (cfg_we) begin
        min_len_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && pdsc_pkg::kind_t'(in_ch.kind) == pdsc_pkg::KIND_EMPTY) begin
        seen_above_r <= 1'b0;
        seen_below_r <= 1'b0;
        seen_on_r    <= 1'b0;
      end
      if (state_r == pdsc_pkg::ST_CLS && post) begin
        seen_above_r <= na && !last_r;
        seen_below_r <= nb && !last_r;
        seen_on_r    <= non && !last_r;
      end
      if (state_r == pdsc_pkg::ST_OFFS && post) begin
        for (int k = 0; k < 3; k++) begin
          normal_r[k] <= nn_r[k];
        end
        offset_r <= pdsc_pkg::sat_plane(-(acc_r >>> Frac));
      end
      if (state_r == pdsc_pkg::ST_NP && post) begin
        for (int k = 0; k < 3; k++) begin
          normal_r[k] <= {{32{pa_r[k][31]}}, pa_r[k]} <<< NormUp;
        end
        offset_r <= pdsc_pkg::sat_plane(-((acc_r <<< NpUp) >>> NpDn));
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    acc_r <= acc_sum;
    if (accept) begin
      kind_r <= pdsc_pkg::kind_t'(in_ch.kind);
      last_r <= in_ch.last;
      pa_r[0] <= in_ch.a_x;  pa_r[1] <= in_ch.a_y;  pa_r[2] <= in_ch.a_z;
      pb_r[0] <= in_ch.b_x;  pb_r[1] <= in_ch.b_y;  pb_r[2] <= in_ch.b_z;
      pc_r[0] <= in_ch.c_x;  pc_r[1] <= in_ch.c_y;  pc_r[2] <= in_ch.c_z;
      res_degen_r <= 1'b0;
      if (pdsc_pkg::kind_t'(in_ch.kind) == pdsc_pkg::KIND_VERTEX) begin
        acc_r <= acc_t'({{64{offset_r[63]}}, offset_r}) <<< Frac;
      end else begin
        acc_r <= '0;
      end
      res_verdict_r <= (pdsc_pkg::kind_t'(in_ch.kind) == pdsc_pkg::KIND_EMPTY)
                       ? pdsc_pkg::VERDICT_BELOW : pdsc_pkg::VERDICT_ON;
    end
    if (post) begin
      acc_r <= '0;
    end
    case (state_r)
      pdsc_pkg::ST_CROSS: if (post) cr_r[comp_r] <= acc_r[67:0];
      pdsc_pkg::ST_ORV: begin
        sv_r <= orv;
        bl_r <= '0;
        if (orv == '0) res_degen_r <= 1'b1;
      end
      pdsc_pkg::ST_BITLEN: begin
        if (sv_r != '0) begin
          sv_r <= sv_r >> 1;
          bl_r <= bl_r + 7'd1;
        end else begin
          sh_r <= {1'b0, bl_r} - 8'sd31;
        end
      end
      pdsc_pkg::ST_SCALE: cs_r[comp_r] <= sc_val[31:0];
      pdsc_pkg::ST_SQRT:  if (sqrt_done) len_r <= sqrt_root;
      pdsc_pkg::ST_CHECK: if (too_short) res_degen_r <= 1'b1;
      pdsc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          nn_r[comp_r] <= cs_r[comp_r][31] ? 64'(-div_q) : div_q;
        end
      end
      pdsc_pkg::ST_CLS: if (post && last_r) res_verdict_r <= cls_verdict;
      default: begin
        if (load_out) begin
          out_verdict_r <= res_verdict_r;
          out_degen_r   <= res_degen_r && (kind_r == pdsc_pkg::KIND_THREE_PTS);
          out_nx_r      <= normal_r[0];
          out_ny_r      <= normal_r[1];
          out_nz_r      <= normal_r[2];
          out_d_r       <= offset_r;
        end
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_verdict_r;
  assign out_ch.degenerate = out_degen_r;
  assign out_ch.normal_x   = out_nx_r;
  assign out_ch.normal_y   = out_ny_r;
  assign out_ch.normal_z   = out_nz_r;
  assign out_ch.plane_d    = out_d_r;

endmodule
